[rtl/time_table_interpolator_unit_assert.svh]
// ----------------------------------------------------------------------------
// time table interpolator assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TIME_TABLE_INTERPOLATOR_UNIT_ASSERT_SVH
`define TIME_TABLE_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TTI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tti assertion failed");

// next-cycle implication
`define TTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tti assertion failed");

`endif

[rtl/tti_pkg.sv]
// ----------------------------------------------------------------------------
// tti_pkg
// types and constants shared by the time table interpolator modules
// ----------------------------------------------------------------------------
package tti_pkg;

    localparam int DW      = 48;
    localparam int SW      = 49;
    localparam int PRW     = 98;
    localparam int CNT_W   = 7;

    localparam logic [CNT_W-1:0] MUL_LAST = 7'd48;
    localparam logic [CNT_W-1:0] DIV_LAST = 7'd97;
    localparam logic [62:0]      QCAP     = 63'h4000_0000_0000_0000;

    localparam logic [1:0] KIND_REAL = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_BOOL = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] REG_POINT_COUNT   = 2'd0;
    localparam logic [1:0] REG_RUNTIME_READY = 2'd1;

    typedef enum logic [1:0] {
        OP_TIME   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_BIND   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        TSEL_ZERO,
        TSEL_LAST,
        TSEL_MID,
        TSEL_ROW,
        TSEL_ROWP1
    } tsel_t;

    typedef enum logic {
        SSEL_ROW,
        SSEL_ROWP1
    } ssel_t;

    typedef enum logic [1:0] {
        ROWSET_ZERO,
        ROWSET_LAST,
        ROWSET_SEARCH
    } rowset_t;

    typedef enum logic [2:0] {
        RES_WRITE,
        RES_FAIL,
        RES_SAMPLE,
        RES_LOW,
        RES_UP,
        RES_INTERP
    } res_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_T0W,
        S_TLW,
        S_BS,
        S_BSW,
        S_SMP,
        S_SMPW,
        S_PR1,
        S_PR2,
        S_PR3,
        S_PREP,
        S_MUL,
        S_DIVI,
        S_DIV,
        S_CAP,
        S_SUM
    } state_t;

    typedef struct packed {
        logic    load;
        logic    do_write;
        logic    t_rd;
        tsel_t   tsel;
        logic    s_rd;
        ssel_t   ssel;
        logic    set_row;
        rowset_t row_sel;
        logic    bs_init;
        logic    bs_step;
        logic    lat_lo;
        logic    lat_hi;
        logic    mul_init;
        logic    mul_step;
        logic    div_init;
        logic    div_step;
        logic    cap;
        logic    finish;
        res_t    res_sel;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic fail;
        logic empty;
        logic kind_real;
        logic n_one;
        logic q_le_t;
        logic q_ge_t;
        logic bs_more;
        logic tie;
        logic trivial;
        logic cnt_last;
    } status_t;

endpackage

[rtl/tti_ctrl.sv]
// ----------------------------------------------------------------------------
// tti_ctrl
// sequencer for writes, table search, lookup and interpolation
// ----------------------------------------------------------------------------
`include "time_table_interpolator_unit_assert.svh"

module tti_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tti_pkg::status_t status,
    output tti_pkg::cmd_t    cmd
);

    tti_pkg::state_t state_reg;
    tti_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tti_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != tti_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            tti_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = tti_pkg::S_DISPATCH;
                end
            end
            tti_pkg::S_DISPATCH:
            begin
                if (!status.is_read)
                begin
                    cmd.do_write = 1'b1;
                    cmd.finish   = 1'b1;
                    cmd.res_sel  = tti_pkg::RES_WRITE;
                    state_next   = tti_pkg::S_IDLE;
                end
                else if (status.fail)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = tti_pkg::RES_FAIL;
                    state_next  = tti_pkg::S_IDLE;
                end
                else if (status.empty)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = status.kind_real ? tti_pkg::RES_WRITE : tti_pkg::RES_FAIL;
                    state_next  = tti_pkg::S_IDLE;
                end
                else
                begin
                    cmd.t_rd   = 1'b1;
                    cmd.tsel   = tti_pkg::TSEL_ZERO;
                    state_next = tti_pkg::S_T0W;
                end
            end
            tti_pkg::S_T0W:
            begin
                if (status.n_one || status.q_le_t)
                begin
                    cmd.set_row = 1'b1;
                    cmd.row_sel = tti_pkg::ROWSET_ZERO;
                    state_next  = tti_pkg::S_SMP;
                end
                else
                begin
                    cmd.t_rd   = 1'b1;
                    cmd.tsel   = tti_pkg::TSEL_LAST;
                    state_next = tti_pkg::S_TLW;
                end
            end
            tti_pkg::S_TLW:
            begin
                if (status.q_ge_t)
                begin
                    cmd.set_row = 1'b1;
                    cmd.row_sel = tti_pkg::ROWSET_LAST;
                    state_next  = tti_pkg::S_SMP;
                end
                else
                begin
                    cmd.bs_init = 1'b1;
                    state_next  = tti_pkg::S_BS;
                end
            end
            tti_pkg::S_BS:
            begin
                if (status.bs_more)
                begin
                    cmd.t_rd   = 1'b1;
                    cmd.tsel   = tti_pkg::TSEL_MID;
                    state_next = tti_pkg::S_BSW;
                end
                else
                begin
                    cmd.set_row = 1'b1;
                    cmd.row_sel = tti_pkg::ROWSET_SEARCH;
                    state_next  = status.kind_real ? tti_pkg::S_PR1 : tti_pkg::S_SMP;
                end
            end
            tti_pkg::S_BSW:
            begin
                cmd.bs_step = 1'b1;
                state_next  = tti_pkg::S_BS;
            end
            tti_pkg::S_SMP:
            begin
                cmd.s_rd   = 1'b1;
                cmd.ssel   = tti_pkg::SSEL_ROW;
                state_next = tti_pkg::S_SMPW;
            end
            tti_pkg::S_SMPW:
            begin
                cmd.finish  = 1'b1;
                cmd.res_sel = tti_pkg::RES_SAMPLE;
                state_next  = tti_pkg::S_IDLE;
            end
            tti_pkg::S_PR1:
            begin
                cmd.t_rd   = 1'b1;
                cmd.tsel   = tti_pkg::TSEL_ROW;
                cmd.s_rd   = 1'b1;
                cmd.ssel   = tti_pkg::SSEL_ROW;
                state_next = tti_pkg::S_PR2;
            end
            tti_pkg::S_PR2:
            begin
                cmd.lat_lo = 1'b1;
                cmd.t_rd   = 1'b1;
                cmd.tsel   = tti_pkg::TSEL_ROWP1;
                cmd.s_rd   = 1'b1;
                cmd.ssel   = tti_pkg::SSEL_ROWP1;
                state_next = tti_pkg::S_PR3;
            end
            tti_pkg::S_PR3:
            begin
                cmd.lat_hi = 1'b1;
                state_next = tti_pkg::S_PREP;
            end
            tti_pkg::S_PREP:
            begin
                if (status.tie)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = tti_pkg::RES_UP;
                    state_next  = tti_pkg::S_IDLE;
                end
                else if (status.trivial)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = tti_pkg::RES_LOW;
                    state_next  = tti_pkg::S_IDLE;
                end
                else
                begin
                    cmd.mul_init = 1'b1;
                    state_next   = tti_pkg::S_MUL;
                end
            end
            tti_pkg::S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = tti_pkg::S_DIVI;
                end
            end
            tti_pkg::S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = tti_pkg::S_DIV;
            end
            tti_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = tti_pkg::S_CAP;
                end
            end
            tti_pkg::S_CAP:
            begin
                cmd.cap    = 1'b1;
                state_next = tti_pkg::S_SUM;
            end
            tti_pkg::S_SUM:
            begin
                cmd.finish  = 1'b1;
                cmd.res_sel = tti_pkg::RES_INTERP;
                state_next  = tti_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tti_pkg::S_IDLE;
            end
        endcase
    end

    `TTI_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `TTI_ASSERT_NEXT(a_mul_to_div, cmd.mul_step && status.cnt_last, state_reg == tti_pkg::S_DIVI)
    `TTI_ASSERT_NEXT(a_finish_idle, cmd.finish, !busy)

endmodule

[rtl/tti_datapath.sv]
// ----------------------------------------------------------------------------
// tti_datapath
// tables, configuration, search registers and shift-add multiply / divide
// ----------------------------------------------------------------------------
`include "time_table_interpolator_unit_assert.svh"

module tti_datapath #(
    parameter int CHANNELS = 8,
    parameter int POINTS   = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              operation,
    input  logic [2:0]              channel,
    input  logic [7:0]              point_index,
    input  logic signed [47:0]      time_word,
    input  logic signed [47:0]      sample_word,
    input  logic [1:0]              value_kind,
    input  logic                    cfg_valid,
    input  logic [1:0]              cfg_index,
    input  logic [8:0]              cfg_data,
    input  tti_pkg::cmd_t           cmd,
    output tti_pkg::status_t        status,
    output logic                    done,
    output logic                    ok,
    output logic signed [47:0]      value_out
);

    localparam int NW  = $clog2(POINTS + 1);
    localparam int RW  = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int SAW = (CHANNELS * POINTS > 1) ? $clog2(CHANNELS * POINTS) : 1;

    localparam logic signed [65:0] MAX66 = 66'sh7FFF_FFFF_FFFF;
    localparam logic signed [65:0] MIN66 = -MAX66 - 66'sd1;

    tti_pkg::op_t              op_reg;
    logic [2:0]                ch_reg;
    logic [7:0]                idx_reg;
    logic signed [47:0]        q_reg;
    logic signed [47:0]        smp_reg;
    logic [1:0]                kind_reg;

    logic [8:0]                pcount_reg;
    logic                      ready_reg;
    logic [1:0]                ch_kind_reg [CHANNELS];

    logic [47:0]               time_mem [POINTS];
    logic [47:0]               sample_mem [CHANNELS * POINTS];
    logic signed [47:0]        t_data_reg;
    logic signed [47:0]        s_data_reg;

    logic [NW-1:0]             lo_reg;
    logic [NW-1:0]             hi_reg;
    logic [RW-1:0]             row_reg;

    logic signed [47:0]        tl_reg;
    logic signed [47:0]        vl_reg;
    logic signed [47:0]        tu_reg;
    logic signed [47:0]        vu_reg;

    logic                      neg_reg;
    logic [48:0]               ma_reg;
    logic [48:0]               den_reg;
    logic [98:0]               p_reg;
    logic [49:0]               rem_reg;
    logic [tti_pkg::CNT_W-1:0] cnt_reg;
    logic [62:0]               qm_reg;

    logic                      done_reg;
    logic                      ok_reg;
    logic signed [47:0]        val_reg;

    logic [NW-1:0]             n_pts;
    logic [NW-1:0]             n_last;
    logic [NW-1:0]             mid;
    logic [NW-1:0]             up;
    logic                      ch_ok;
    logic [1:0]                bound_kind;
    logic [RW-1:0]             t_addr;
    logic [RW-1:0]             s_row;
    logic [SAW-1:0]            s_addr;
    logic [SAW-1:0]            w_addr;
    logic                      row_ok;
    logic signed [48:0]        num;
    logic signed [48:0]        den;
    logic signed [48:0]        dv;
    logic [49:0]               mul_sum;
    logic [49:0]               div_t;
    logic                      div_ge;
    logic signed [65:0]        sum66;
    logic signed [47:0]        interp_val;
    logic signed [47:0]        val_next;
    logic                      ok_next;

    function automatic logic [48:0] mag49(input logic signed [48:0] v);
        logic [48:0] r;
        r = v[48] ? 49'(-v) : 49'(v);
        return r;
    endfunction

    assign n_pts  = (32'(pcount_reg) > POINTS) ? NW'(POINTS) : NW'(pcount_reg);
    assign n_last = n_pts - NW'(1);
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign up     = (lo_reg < NW'(1)) ? NW'(1) : ((lo_reg > n_last) ? n_last : lo_reg);
    assign ch_ok  = (32'(ch_reg) < CHANNELS);
    assign row_ok = (32'(idx_reg) < POINTS);

    always_comb
    begin
        bound_kind = tti_pkg::KIND_NONE;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (32'(ch_reg) == i)
            begin
                bound_kind = ch_kind_reg[i];
            end
        end
    end

    always_comb
    begin
        case (cmd.tsel)
            tti_pkg::TSEL_ZERO:  t_addr = '0;
            tti_pkg::TSEL_LAST:  t_addr = RW'(n_last);
            tti_pkg::TSEL_MID:   t_addr = RW'(mid);
            tti_pkg::TSEL_ROW:   t_addr = row_reg;
            tti_pkg::TSEL_ROWP1: t_addr = row_reg + RW'(1);
            default:             t_addr = '0;
        endcase
    end

    assign s_row  = (cmd.ssel == tti_pkg::SSEL_ROWP1) ? row_reg + RW'(1) : row_reg;
    assign s_addr = SAW'(32'(ch_reg) * POINTS + 32'(s_row));
    assign w_addr = SAW'(32'(ch_reg) * POINTS + 32'(idx_reg));

    // item and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= '0;
            ready_reg  <= 1'b0;
            done_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ch_kind_reg[i] <= tti_pkg::KIND_NONE;
            end
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_valid)
            begin
                case (cfg_index)
                    tti_pkg::REG_POINT_COUNT:   pcount_reg <= cfg_data;
                    tti_pkg::REG_RUNTIME_READY: ready_reg  <= cfg_data[0];
                    default:                    ;
                endcase
            end
            if (cmd.do_write && op_reg == tti_pkg::OP_BIND)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (32'(ch_reg) == i)
                    begin
                        ch_kind_reg[i] <= kind_reg;
                    end
                end
            end
        end
    end

    // tables
    always_ff @(posedge clk)
    begin
        if (cmd.do_write && op_reg == tti_pkg::OP_TIME && row_ok)
        begin
            time_mem[RW'(idx_reg)] <= q_reg;
        end
        if (cmd.t_rd)
        begin
            t_data_reg <= time_mem[t_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_write && op_reg == tti_pkg::OP_SAMPLE && row_ok && ch_ok)
        begin
            sample_mem[w_addr] <= smp_reg;
        end
        if (cmd.s_rd)
        begin
            s_data_reg <= sample_mem[s_addr];
        end
    end

    assign num = {q_reg[47], q_reg} - {tl_reg[47], tl_reg};
    assign den = {tu_reg[47], tu_reg} - {tl_reg[47], tl_reg};
    assign dv  = {vu_reg[47], vu_reg} - {vl_reg[47], vl_reg};

    assign mul_sum = p_reg[98:49] + (p_reg[0] ? {1'b0, ma_reg} : 50'd0);
    assign div_t   = {rem_reg[48:0], p_reg[97]};
    assign div_ge  = (div_t >= {1'b0, den_reg});

    assign sum66 = neg_reg ? 66'(vl_reg) - $signed({3'b000, qm_reg})
                           : 66'(vl_reg) + $signed({3'b000, qm_reg});
    assign interp_val = (sum66 > MAX66) ? MAX66[47:0]
                      : ((sum66 < MIN66) ? MIN66[47:0] : sum66[47:0]);

    always_comb
    begin
        ok_next  = 1'b1;
        val_next = '0;
        case (cmd.res_sel)
            tti_pkg::RES_WRITE:  ;
            tti_pkg::RES_FAIL:   ok_next = 1'b0;
            tti_pkg::RES_SAMPLE:
            begin
                if (kind_reg == tti_pkg::KIND_BOOL)
                begin
                    val_next = (s_data_reg != '0) ? 48'sd1 : 48'sd0;
                end
                else
                begin
                    val_next = s_data_reg;
                end
            end
            tti_pkg::RES_LOW:    val_next = vl_reg;
            tti_pkg::RES_UP:     val_next = vu_reg;
            tti_pkg::RES_INTERP: val_next = interp_val;
            default:             ok_next = 1'b0;
        endcase
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= tti_pkg::op_t'(operation);
            ch_reg   <= channel;
            idx_reg  <= point_index;
            q_reg    <= time_word;
            smp_reg  <= sample_word;
            kind_reg <= value_kind;
        end
        if (cmd.bs_init)
        begin
            lo_reg <= '0;
            hi_reg <= n_pts;
        end
        if (cmd.bs_step)
        begin
            if (t_data_reg <= q_reg)
            begin
                lo_reg <= mid + NW'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.set_row)
        begin
            case (cmd.row_sel)
                tti_pkg::ROWSET_ZERO:   row_reg <= '0;
                tti_pkg::ROWSET_LAST:   row_reg <= RW'(n_last);
                tti_pkg::ROWSET_SEARCH: row_reg <= RW'(up - NW'(1));
                default:                row_reg <= '0;
            endcase
        end
        if (cmd.lat_lo)
        begin
            tl_reg <= t_data_reg;
            vl_reg <= s_data_reg;
        end
        if (cmd.lat_hi)
        begin
            tu_reg <= t_data_reg;
            vu_reg <= s_data_reg;
        end
        if (cmd.mul_init)
        begin
            neg_reg <= num[48] ^ den[48] ^ dv[48];
            ma_reg  <= mag49(dv);
            den_reg <= mag49(den);
            p_reg   <= {50'd0, mag49(num)};
            cnt_reg <= tti_pkg::MUL_LAST;
        end
        if (cmd.mul_step)
        begin
            p_reg   <= {1'b0, mul_sum, p_reg[48:1]};
            cnt_reg <= cnt_reg - tti_pkg::CNT_W'(1);
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            cnt_reg <= tti_pkg::DIV_LAST;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_t - {1'b0, den_reg} : div_t;
            p_reg   <= {1'b0, p_reg[96:0], div_ge};
            cnt_reg <= cnt_reg - tti_pkg::CNT_W'(1);
        end
        if (cmd.cap)
        begin
            qm_reg <= (p_reg[97:0] > 98'(tti_pkg::QCAP)) ? tti_pkg::QCAP : p_reg[62:0];
        end
        if (cmd.finish)
        begin
            ok_reg  <= ok_next;
            val_reg <= val_next;
        end
    end

    assign status.is_read   = (op_reg == tti_pkg::OP_READ);
    assign status.fail      = !ready_reg || !ch_ok || kind_reg == tti_pkg::KIND_NONE
                              || bound_kind != kind_reg;
    assign status.empty     = (n_pts == '0);
    assign status.kind_real = (kind_reg == tti_pkg::KIND_REAL);
    assign status.n_one     = (n_pts == NW'(1));
    assign status.q_le_t    = (q_reg <= t_data_reg);
    assign status.q_ge_t    = (q_reg >= t_data_reg);
    assign status.bs_more   = (lo_reg < hi_reg);
    assign status.tie       = (tu_reg == tl_reg);
    assign status.trivial   = (dv == '0) || (num == '0);
    assign status.cnt_last  = (cnt_reg == '0);

    assign done      = done_reg;
    assign ok        = ok_reg;
    assign value_out = val_reg;

    `TTI_ASSERT_SAME(a_done_after_finish, done_reg, $past(cmd.finish))
    `TTI_ASSERT_NEXT(a_fail_result, cmd.finish && cmd.res_sel == tti_pkg::RES_FAIL, !ok_reg)
    `TTI_ASSERT_SAME(a_bool_range, done_reg && ok_reg && kind_reg == tti_pkg::KIND_BOOL
                     && op_reg == tti_pkg::OP_READ, val_reg == 48'sd0 || val_reg == 48'sd1)

endmodule

[rtl/time_table_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// time_table_interpolator_unit
// One item at a time, taken when start is high and busy low. Writes and kind
// binds, and reads that fail or hit an empty table, finish in the dispatch
// state. Integer and boolean reads may run a binary search over the time
// memory (up to nine probes, single read port). Real reads that interpolate
// run the search, four table reads, a 49-step shift-add multiply and a
// 98-step restoring divide, one bit per cycle each. done is high for exactly
// one cycle and cannot be held off, and a new item may be started in that
// same cycle; ok and value_out hold the result until the next one. Config
// writes are always taken (cfg_ready is tied high); the user must keep them
// to idle periods, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module time_table_interpolator_unit #(
    parameter int CHANNELS = 8,
    parameter int POINTS   = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [2:0]         channel,
    input  logic [7:0]         point_index,
    input  logic signed [47:0] time_word,
    input  logic signed [47:0] sample_word,
    input  logic [1:0]         value_kind,
    output logic               done,
    output logic               ok,
    output logic signed [47:0] value_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);

    tti_pkg::cmd_t    cmd;
    tti_pkg::status_t status;

    assign cfg_ready = 1'b1;

    tti_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    tti_datapath #(
        .CHANNELS (CHANNELS),
        .POINTS   (POINTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .channel     (channel),
        .point_index (point_index),
        .time_word   (time_word),
        .sample_word (sample_word),
        .value_kind  (value_kind),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .done        (done),
        .ok          (ok),
        .value_out   (value_out)
    );

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: time table interpolator testbench
// Loads time and sample tables, binds channel kinds and reads values back,
// predicting each result from a local copy of the tables and configuration.
// Results are checked in order as they are strobed out.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic signed [47:0] MAX48      = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48      = 48'sh8000_0000_0000;
    localparam logic [127:0]       CAP        = 128'h4000_0000_0000_0000;
    localparam logic [1:0]         REG_UNUSED = 2'd3;

    typedef struct {
        logic               ok;
        logic signed [47:0] value;
    } reading_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         operation = 2'd0;
    logic [2:0]         channel = 3'd0;
    logic [7:0]         point_index = 8'd0;
    logic signed [47:0] time_word = 48'sd0;
    logic signed [47:0] sample_word = 48'sd0;
    logic [1:0]         value_kind = 2'd0;
    logic               done;
    logic               ok;
    logic signed [47:0] value_out;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = 2'd0;
    logic [8:0]         cfg_data = 9'd0;

    logic signed [47:0] time_mem [256];
    logic signed [47:0] sample_mem [8][256];
    bit                 time_set [256];
    bit                 sample_set [8][256];
    logic [1:0]         chan_kind [8];
    int unsigned        point_count_q = 0;
    bit                 ready_q = 0;

    reading_t expected_readings[$];
    int       mismatches = 0;
    int       items_sent = 0;
    bit       no_gaps = 0;

    always #4 clk = ~clk;

    time_table_interpolator_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .channel(channel), .point_index(point_index),
        .time_word(time_word), .sample_word(sample_word), .value_kind(value_kind),
        .done(done), .ok(ok), .value_out(value_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    task automatic flag_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int used_points();
        return (point_count_q > 256) ? 256 : int'(point_count_q);
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int upper_row(logic signed [47:0] q, int n);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (time_mem[mid] <= q) lo = mid + 1;
            else hi = mid;
        end
        if (lo < 1) lo = 1;
        if (lo > n - 1) lo = n - 1;
        return lo;
    endfunction

    function automatic int hold_row(logic signed [47:0] q, int n);
        if (n == 1 || q <= time_mem[0]) return 0;
        if (q >= time_mem[n-1]) return n - 1;
        return upper_row(q, n) - 1;
    endfunction

    function automatic logic signed [47:0] interp_value(int ch, logic signed [47:0] q, int n);
        int           up;
        longint       tl, tu, vl, vu, num, den, dv, res;
        logic [127:0] a, b, d, qm;
        bit           neg;
        if (n == 0) return 48'sd0;
        if (n == 1 || q <= time_mem[0]) return sample_mem[ch][0];
        if (q >= time_mem[n-1]) return sample_mem[ch][n-1];
        up = upper_row(q, n);
        tl = time_mem[up-1];
        tu = time_mem[up];
        vl = sample_mem[ch][up-1];
        vu = sample_mem[ch][up];
        if (tu == tl) return sample_mem[ch][up];
        num = longint'(q) - tl;
        den = tu - tl;
        dv = vu - vl;
        neg = (num < 0) ^ (den < 0) ^ (dv < 0);
        a = 128'(magnitude(dv));
        b = 128'(magnitude(num));
        d = 128'(magnitude(den));
        qm = (a * b) / d;
        if (qm > CAP) qm = CAP;
        res = neg ? vl - longint'(qm[63:0]) : vl + longint'(qm[63:0]);
        if (dv == 0 || num == 0) res = vl;
        if (res > longint'(MAX48)) res = MAX48;
        if (res < longint'(MIN48)) res = MIN48;
        return res[47:0];
    endfunction

    function automatic reading_t predict_item(tti_pkg::op_t op, logic [2:0] ch,
                                              logic [7:0] row,
                                              logic signed [47:0] tw,
                                              logic signed [47:0] sw,
                                              logic [1:0] kind);
        reading_t r;
        int       n;
        r.ok = 1'b1;
        r.value = 48'sd0;
        n = used_points();
        case (op)
            tti_pkg::OP_TIME:
            begin
                time_mem[row] = tw;
                time_set[row] = 1;
            end
            tti_pkg::OP_SAMPLE:
            begin
                sample_mem[ch][row] = sw;
                sample_set[ch][row] = 1;
            end
            tti_pkg::OP_BIND: chan_kind[ch] = kind;
            default:
            begin
                r.ok = 1'b0;
                if (ready_q && kind != tti_pkg::KIND_NONE && chan_kind[ch] == kind)
                begin
                    if (kind == tti_pkg::KIND_REAL)
                    begin
                        r.value = interp_value(int'(ch), tw, n);
                        r.ok = 1'b1;
                    end
                    else if (n > 0)
                    begin
                        r.value = sample_mem[ch][hold_row(tw, n)];
                        if (kind == tti_pkg::KIND_BOOL)
                            r.value = (r.value != 0) ? 48'sd1 : 48'sd0;
                        r.ok = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // a read may only touch rows that have been written
    function automatic bit read_allowed(logic [2:0] ch, logic [1:0] kind);
        int n;
        n = used_points();
        if (!ready_q || kind == tti_pkg::KIND_NONE || chan_kind[ch] != kind || n == 0)
            return 1;
        for (int r = 0; r < n; r++)
            if (!time_set[r] || !sample_set[ch][r]) return 0;
        return 1;
    endfunction

    always @(posedge clk)
    begin
        reading_t e;
        if (rst_n && done)
        begin
            if (expected_readings.size() == 0)
            begin
                flag_mismatch("result with no item outstanding");
            end
            else
            begin
                e = expected_readings.pop_front();
                if (ok !== e.ok)
                    flag_mismatch($sformatf("ok %b, expected %b", ok, e.ok));
                if (value_out !== e.value)
                    flag_mismatch($sformatf("value_out %0d, expected %0d",
                                            value_out, e.value));
            end
        end
    end

    task automatic send_item(tti_pkg::op_t op, logic [2:0] ch, logic [7:0] row,
                             logic signed [47:0] tw, logic signed [47:0] sw,
                             logic [1:0] kind);
        int gap;
        start <= 1'b1;
        operation <= op;
        channel <= ch;
        point_index <= row;
        time_word <= tw;
        sample_word <= sw;
        value_kind <= kind;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_readings.push_back(predict_item(op, ch, row, tw, sw, kind));
        items_sent++;
        gap = 0;
        if (!no_gaps)
        begin
            case ($urandom_range(0, 19))
                0:             gap = $urandom_range(20, 120);
                1, 2, 3, 4, 5: gap = $urandom_range(1, 4);
                default:       gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        int waited;
        start <= 1'b0;
        waited = 0;
        while (expected_readings.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == tti_pkg::REG_POINT_COUNT) point_count_q = data;
        else if (idx == tti_pkg::REG_RUNTIME_READY) ready_q = data[0];
        @(posedge clk);
    endtask

    function automatic logic signed [47:0] rand48();
        logic [63:0] u;
        u = {$urandom, $urandom};
        return u[47:0];
    endfunction

    function automatic logic signed [47:0] rand_sample(logic [1:0] kind);
        case ($urandom_range(0, 9))
            0, 1: return rand48();
            2:    return MAX48;
            3:    return MIN48;
            4:    return 48'sd0;
            default:
            begin
                if (kind == tti_pkg::KIND_BOOL) return 48'($urandom_range(0, 1));
                return 48'(longint'($urandom_range(0, 1 << 21)) - (1 << 20));
            end
        endcase
    endfunction

    function automatic logic signed [47:0] rand_time();
        if ($urandom_range(0, 4) == 0) return rand48();
        return 48'(longint'($urandom_range(0, 1 << 25)) - (1 << 24));
    endfunction

    function automatic logic signed [47:0] pick_query(int n);
        int          r;
        longint      lo, hi;
        logic [63:0] u;
        if (n == 0) return rand_time();
        r = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: return rand48();
            1: return time_mem[r];
            2:
            begin
                lo = time_mem[r];
                hi = (r + 1 < n) ? longint'(time_mem[r+1]) : lo;
                if (hi <= lo) return 48'(lo);
                u = {$urandom, $urandom};
                u = u % 64'(hi - lo + 1);
                return 48'(lo + longint'(u));
            end
            3: return 48'(longint'(time_mem[r]) + longint'($urandom_range(0, 64)) - 32);
            4: return $urandom_range(0, 1) ? MAX48 : MIN48;
            default: return rand_time();
        endcase
    endfunction

    task automatic load_table(int n, bit [7:0] chans, bit sorted);
        longint t [256];
        longint tmp;
        for (int r = 0; r < n; r++) t[r] = rand_time();
        if (sorted)
            for (int i = 1; i < n; i++)
                for (int j = i; j > 0 && t[j-1] > t[j]; j--)
                begin
                    tmp = t[j];
                    t[j] = t[j-1];
                    t[j-1] = tmp;
                end
        for (int r = 0; r < n; r++)
            send_item(tti_pkg::OP_TIME, 3'($urandom), 8'(r), 48'(t[r]), rand48(),
                      2'($urandom));
        for (int c = 0; c < 8; c++)
            if (chans[c])
                for (int r = 0; r < n; r++)
                    send_item(tti_pkg::OP_SAMPLE, 3'(c), 8'(r), rand48(),
                              rand_sample(chan_kind[c]), 2'($urandom));
    endtask

    task automatic random_read(int n);
        logic [2:0] ch;
        logic [1:0] kind;
        for (int tries = 0; tries < 20; tries++)
        begin
            ch = 3'($urandom);
            kind = ($urandom_range(0, 5) == 0) ? 2'($urandom) : chan_kind[ch];
            if (read_allowed(ch, kind))
            begin
                send_item(tti_pkg::OP_READ, ch, 8'($urandom), pick_query(n), rand48(), kind);
                return;
            end
        end
        send_item(tti_pkg::OP_BIND, 3'($urandom), 8'($urandom), rand48(), rand48(),
                  2'($urandom));
    endtask

    task automatic test_directed();
        send_item(tti_pkg::OP_BIND, 3'd0, 8'd0, 48'sd0, 48'sd0, tti_pkg::KIND_REAL);
        send_item(tti_pkg::OP_BIND, 3'd1, 8'd0, 48'sd0, 48'sd0, tti_pkg::KIND_INT);
        send_item(tti_pkg::OP_BIND, 3'd2, 8'd0, 48'sd0, 48'sd0, tti_pkg::KIND_BOOL);
        send_item(tti_pkg::OP_BIND, 3'd7, 8'd0, 48'sd0, 48'sd0, tti_pkg::KIND_NONE);
        send_item(tti_pkg::OP_READ, 3'd0, 8'd0, 48'sd0, 48'sd0, tti_pkg::KIND_REAL);
        drain();
        cfg_write(tti_pkg::REG_RUNTIME_READY, 9'd1);
        cfg_write(tti_pkg::REG_POINT_COUNT, 9'd0);
        send_item(tti_pkg::OP_READ, 3'd0, 8'd0, 48'sh10000, 48'sd0, tti_pkg::KIND_REAL);
        send_item(tti_pkg::OP_READ, 3'd1, 8'd0, 48'sd0, 48'sd0, tti_pkg::KIND_INT);
        send_item(tti_pkg::OP_READ, 3'd7, 8'd0, 48'sd0, 48'sd0, tti_pkg::KIND_NONE);
        send_item(tti_pkg::OP_READ, 3'd0, 8'd0, 48'sd0, 48'sd0, tti_pkg::KIND_INT);
        send_item(tti_pkg::OP_TIME, 3'd0, 8'd0, MIN48, 48'sd0, tti_pkg::KIND_REAL);
        send_item(tti_pkg::OP_TIME, 3'd0, 8'd1, 48'sd0, 48'sd0, tti_pkg::KIND_REAL);
        send_item(tti_pkg::OP_TIME, 3'd0, 8'd2, 48'sh10000, 48'sd0, tti_pkg::KIND_REAL);
        send_item(tti_pkg::OP_TIME, 3'd0, 8'd3, MAX48, 48'sd0, tti_pkg::KIND_REAL);
        for (int r = 0; r < 4; r++)
        begin
            send_item(tti_pkg::OP_SAMPLE, 3'd0, 8'(r), 48'sd0, (r % 2) ? MIN48 : MAX48,
                      tti_pkg::KIND_REAL);
            send_item(tti_pkg::OP_SAMPLE, 3'd1, 8'(r), 48'sd0, 48'(r * 5 - 7),
                      tti_pkg::KIND_REAL);
            send_item(tti_pkg::OP_SAMPLE, 3'd2, 8'(r), 48'sd0,
                      (r == 1) ? 48'sd3 : 48'sd0, tti_pkg::KIND_REAL);
        end
        drain();
        cfg_write(tti_pkg::REG_POINT_COUNT, 9'd4);
        send_item(tti_pkg::OP_READ, 3'd0, 8'd0, MIN48, 48'sd0, tti_pkg::KIND_REAL);
        send_item(tti_pkg::OP_READ, 3'd0, 8'd0, MAX48, 48'sd0, tti_pkg::KIND_REAL);
        send_item(tti_pkg::OP_READ, 3'd0, 8'd0, 48'sh8000, 48'sd0, tti_pkg::KIND_REAL);
        send_item(tti_pkg::OP_READ, 3'd0, 8'd0, -48'sd5, 48'sd0, tti_pkg::KIND_REAL);
        send_item(tti_pkg::OP_READ, 3'd1, 8'd0, 48'sh8000, 48'sd0, tti_pkg::KIND_INT);
        send_item(tti_pkg::OP_READ, 3'd2, 8'd0, 48'sh0, 48'sd0, tti_pkg::KIND_BOOL);
        drain();
        cfg_write(tti_pkg::REG_POINT_COUNT, 9'd1);
        send_item(tti_pkg::OP_READ, 3'd0, 8'd0, MAX48, 48'sd0, tti_pkg::KIND_REAL);
        drain();
        cfg_write(REG_UNUSED, 9'($urandom));
    endtask

    task automatic test_full_table();
        no_gaps = 1;
        drain();
        cfg_write(tti_pkg::REG_RUNTIME_READY, 9'd1);
        send_item(tti_pkg::OP_BIND, 3'd0, 8'd0, 48'sd0, 48'sd0, tti_pkg::KIND_REAL);
        load_table(256, 8'h01, 1);
        no_gaps = 0;
        drain();
        cfg_write(tti_pkg::REG_POINT_COUNT, 9'd256);
        repeat (25)
            send_item(tti_pkg::OP_READ, 3'd0, 8'($urandom), pick_query(256), rand48(),
                      tti_pkg::KIND_REAL);
        send_item(tti_pkg::OP_BIND, 3'd0, 8'd0, 48'sd0, 48'sd0, tti_pkg::KIND_INT);
        repeat (10)
            send_item(tti_pkg::OP_READ, 3'd0, 8'($urandom), pick_query(256), rand48(),
                      tti_pkg::KIND_INT);
        drain();
        cfg_write(tti_pkg::REG_POINT_COUNT, 9'd511);
        repeat (10)
            send_item(tti_pkg::OP_READ, 3'd0, 8'($urandom), pick_query(256), rand48(),
                      tti_pkg::KIND_INT);
        drain();
        cfg_write(tti_pkg::REG_RUNTIME_READY, 9'd0);
        repeat (3)
            send_item(tti_pkg::OP_READ, 3'd0, 8'($urandom), rand48(), rand48(),
                      tti_pkg::KIND_INT);
    endtask

    task automatic test_random();
        int       n;
        bit [7:0] chans;
        while (items_sent < 1100)
        begin
            case ($urandom_range(0, 19))
                0:          n = 0;
                1, 2:       n = 1;
                3, 4, 5:    n = $urandom_range(9, 40);
                default:    n = $urandom_range(2, 8);
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            drain();
            cfg_write(tti_pkg::REG_RUNTIME_READY, 9'($urandom_range(0, 7) != 0));
            cfg_write(tti_pkg::REG_POINT_COUNT, 9'(n));
            for (int c = 0; c < 8; c++)
                if ($urandom_range(0, 2) == 0)
                    send_item(tti_pkg::OP_BIND, 3'(c), 8'($urandom), rand48(), rand48(),
                              ($urandom_range(0, 7) == 0) ? tti_pkg::KIND_NONE
                                                          : 2'($urandom_range(0, 2)));
            chans = 8'($urandom);
            if (chans == 0) chans = 8'h01 << $urandom_range(0, 7);
            if (n > 12) chans = chans & (8'h01 << $urandom_range(0, 7));
            if (chans == 0) chans = 8'h80;
            load_table(n, chans, $urandom_range(0, 4) != 0);
            repeat ($urandom_range(8, 24))
            begin
                case ($urandom_range(0, 11))
                    0: if (n > 0)
                           send_item(tti_pkg::OP_SAMPLE, 3'($urandom),
                                     8'($urandom_range(0, n - 1)), rand48(),
                                     rand_sample(2'($urandom)), 2'($urandom));
                    1: send_item(tti_pkg::OP_BIND, 3'($urandom), 8'($urandom), rand48(),
                                 rand48(), 2'($urandom));
                    default: random_read(n);
                endcase
            end
        end
    endtask

    initial
    begin
        for (int c = 0; c < 8; c++) chan_kind[c] = tti_pkg::KIND_NONE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random();
        drain();
        repeat (200) @(posedge clk);
        if (expected_readings.size() != 0)
            flag_mismatch("items left without a result");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(8 * 3000000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
